/* src/volume_fade_out_controller_defines.svh */
// Assertion macros used by the top-level file, which carries the concurrent checks.
`ifndef VOLUME_FADE_OUT_CONTROLLER_DEFINES_SVH
`define VOLUME_FADE_OUT_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define VFOC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define VFOC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* src/vfoc_pkg.sv */
`timescale 1ns / 1ps
package vfoc_pkg;

	localparam int LEVEL_FRAC_BITS_DEF = 23;
	localparam int STEP_COUNT_BITS_DEF = 16;
	localparam int VOL_W = 16;
	localparam int STEPS_IN_W = 16;
	localparam logic [VOL_W-1:0] MASTER_RESET = 16'd32768;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_START = 2'd1,
		MODE_STOP  = 2'd2,
		MODE_NOP   = 2'd3
	} vfoc_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_PUSH
	} vfoc_state_t;

	typedef struct packed {
		logic accept;
		logic div_start;
		logic step_load;
		logic mul_en;
		logic out_load;
	} vfoc_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} vfoc_sts_t;

endpackage

/* src/volume_fade_out_controller.sv */
`timescale 1ns / 1ps
// Playback volume controller with a linear fade-out ramp. Each accepted transaction on the
// input channel yields exactly one transaction on the output channel. A tick, a start, a no-op
// or a stop that starts no fade returns to ready after the decode, multiply and output-load steps;
// the output load waits while an earlier result is still untaken. A stop that starts a fade
// (playback active, nonzero step count) first runs the serial divider, which produces one
// quotient bit per cycle. The level is Q1.23 by default.
// A finished result waits in the output register while the next transaction is accepted.
// The user must write master_volume with cfg_we only while no transaction is in flight; the block does not check it.
`include "volume_fade_out_controller_defines.svh"
module volume_fade_out_controller #(
	parameter int LEVEL_FRAC_BITS = vfoc_pkg::LEVEL_FRAC_BITS_DEF,
	parameter int STEP_COUNT_BITS = vfoc_pkg::STEP_COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vfoc_pkg::VOL_W-1:0]      master_volume,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      mode,
	input  logic [vfoc_pkg::STEPS_IN_W-1:0] fade_steps,
	input  logic                            start_ok,
	input  logic                            player_playing,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [vfoc_pkg::VOL_W-1:0]      volume,
	output logic                            volume_valid,
	output logic                            halt_player,
	output logic                            active,
	output logic                            fading
);
	import vfoc_pkg::*;

	vfoc_cmd_t cmd;
	vfoc_sts_t sts;

	vfoc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vfoc_dp #(
		.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS),
		.STEP_COUNT_BITS(STEP_COUNT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.master_volume (master_volume),
		.mode          (mode),
		.fade_steps    (fade_steps),
		.start_ok      (start_ok),
		.player_playing(player_playing),
		.volume        (volume),
		.volume_valid  (volume_valid),
		.halt_player   (halt_player),
		.active        (active),
		.fading        (fading)
	);

	// The divider finishes only while a transaction is in flight.
	`VFOC_ASSERT_IMPLIES(a_div_done_busy, clk, arst_n, sts.div_done, !in_ready)
	// An accepted transaction keeps the input side closed in the next cycle.
	`VFOC_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && in_ready, !in_ready)
	// A pending result is never overwritten before it is taken.
	`VFOC_ASSERT_IMPLIES(a_load_free, clk, arst_n, cmd.out_load, !out_valid || out_ready)
	// Loading a result always presents it on the next cycle.
	`VFOC_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.out_load, out_valid)

endmodule

/* src/vfoc_div.sv */
`timescale 1ns / 1ps
module vfoc_div #(
	parameter int DIVIDEND_W = 24,
	parameter int DIVISOR_W  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);
	localparam int CW = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    shifted;
	logic                  fits;
	logic [DIVISOR_W:0]    diff;

	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits    = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* src/vfoc_ctrl.sv */
`timescale 1ns / 1ps
module vfoc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  vfoc_pkg::vfoc_sts_t sts,
	output vfoc_pkg::vfoc_cmd_t cmd
);
	import vfoc_pkg::*;

	vfoc_state_t state_q;
	vfoc_state_t state_nx;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = sts.need_div ? ST_DIV : ST_MUL;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_nx = ST_MUL;
				end
			end
			ST_MUL: begin
				state_nx = ST_PUSH;
			end
			ST_PUSH: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd            = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.accept    = in_valid;
				cmd.div_start = in_valid && sts.need_div;
			end
			ST_DIV: begin
				cmd.step_load = sts.div_done;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
			end
			ST_PUSH: begin
				cmd.out_load = out_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* src/vfoc_dp.sv */
`timescale 1ns / 1ps
module vfoc_dp #(
	parameter int LEVEL_FRAC_BITS = vfoc_pkg::LEVEL_FRAC_BITS_DEF,
	parameter int STEP_COUNT_BITS = vfoc_pkg::STEP_COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vfoc_pkg::vfoc_cmd_t         cmd,
	output vfoc_pkg::vfoc_sts_t         sts,
	input  logic                        cfg_we,
	input  logic [vfoc_pkg::VOL_W-1:0]  master_volume,
	input  logic [1:0]                  mode,
	input  logic [vfoc_pkg::STEPS_IN_W-1:0] fade_steps,
	input  logic                        start_ok,
	input  logic                        player_playing,
	output logic [vfoc_pkg::VOL_W-1:0]  volume,
	output logic                        volume_valid,
	output logic                        halt_player,
	output logic                        active,
	output logic                        fading
);
	import vfoc_pkg::*;

	localparam int LW   = LEVEL_FRAC_BITS + 1;
	localparam int SCW  = STEP_COUNT_BITS;
	localparam int SATW = (SCW > STEPS_IN_W) ? SCW : STEPS_IN_W;
	localparam int PW   = LW + VOL_W;
	localparam logic [LW-1:0]   LevelOne   = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
	localparam logic [SATW-1:0] StepMaxExt = SATW'({SCW{1'b1}});

	logic [VOL_W-1:0] master_q;
	logic             active_q;
	logic [SCW-1:0]   steps_left_q;
	logic [LW-1:0]    level_q;
	logic [LW-1:0]    step_q;
	logic             target_one_q;
	logic             vvalid_q;
	logic             halt_q;
	logic [PW-1:0]    prod_q;

	logic             active_nx;
	logic [SCW-1:0]   steps_left_nx;
	logic [LW-1:0]    level_nx;
	logic [LW-1:0]    step_nx;
	logic             target_one_nx;
	logic             vvalid_nx;
	logic             halt_nx;
	logic             need_div;
	logic [SATW-1:0]  steps_ext;
	logic [SCW-1:0]   steps_sat;
	logic [SCW-1:0]   left_dec;
	logic             div_done;
	logic [LW-1:0]    quotient;
	logic [VOL_W:0]   vol_wide;

	assign steps_ext = SATW'(fade_steps);
	assign steps_sat = (steps_ext > StepMaxExt) ? SCW'(StepMaxExt) : SCW'(steps_ext);
	assign left_dec  = steps_left_q - 1'b1;

	always_comb begin
		active_nx     = active_q;
		steps_left_nx = steps_left_q;
		level_nx      = level_q;
		step_nx       = step_q;
		target_one_nx = target_one_q;
		vvalid_nx     = 1'b0;
		halt_nx       = 1'b0;
		need_div      = 1'b0;
		unique case (vfoc_mode_t'(mode))
			MODE_START: begin
				halt_nx       = active_q;
				level_nx      = LevelOne;
				step_nx       = LevelOne;
				target_one_nx = 1'b1;
				steps_left_nx = '0;
				vvalid_nx     = 1'b1;
				active_nx     = start_ok;
			end
			MODE_STOP: begin
				if (active_q) begin
					if (steps_sat == '0) begin
						halt_nx   = 1'b1;
						active_nx = 1'b0;
					end else begin
						target_one_nx = 1'b0;
						steps_left_nx = steps_sat;
						need_div      = 1'b1;
					end
				end
			end
			MODE_TICK: begin
				if (steps_left_q != '0) begin
					steps_left_nx = left_dec;
					if (left_dec != '0) begin
						level_nx  = (level_q > step_q) ? (level_q - step_q) : '0;
						vvalid_nx = 1'b1;
					end else begin
						level_nx = target_one_q ? LevelOne : '0;
						if (active_q) begin
							halt_nx   = 1'b1;
							active_nx = 1'b0;
						end
					end
				end
				active_nx = active_nx && player_playing;
			end
			MODE_NOP: begin
			end
		endcase
	end

	assign sts.need_div = need_div;
	assign sts.div_done = div_done;

	vfoc_div #(
		.DIVIDEND_W(LW),
		.DIVISOR_W (SCW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(level_q),
		.divisor (steps_sat),
		.done    (div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q     <= MASTER_RESET;
			active_q     <= 1'b0;
			steps_left_q <= '0;
			level_q      <= LevelOne;
			step_q       <= LevelOne;
			target_one_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				master_q <= master_volume;
			end
			if (cmd.accept) begin
				active_q     <= active_nx;
				steps_left_q <= steps_left_nx;
				level_q      <= level_nx;
				step_q       <= step_nx;
				target_one_q <= target_one_nx;
			end else if (cmd.step_load) begin
				step_q <= quotient;
			end
		end
	end

	assign vol_wide = prod_q[PW-1:LEVEL_FRAC_BITS];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			vvalid_q <= vvalid_nx;
			halt_q   <= halt_nx;
		end
		if (cmd.mul_en) begin
			prod_q <= PW'(level_q) * PW'(master_q);
		end
		if (cmd.out_load) begin
			volume       <= vol_wide[VOL_W] ? {VOL_W{1'b1}} : vol_wide[VOL_W-1:0];
			volume_valid <= vvalid_q;
			halt_player  <= halt_q;
			active       <= active_q;
			fading       <= steps_left_q != '0;
		end
	end

endmodule

/* verif/volume_fade_out_controller_test.sv */
`timescale 1ns / 1ps
module volume_fade_out_controller_test;
	import vfoc_pkg::*;

	localparam int LEVEL_FRAC = LEVEL_FRAC_BITS_DEF;
	localparam int LEVEL_W = LEVEL_FRAC_BITS_DEF + 1;
	localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << LEVEL_FRAC;
	localparam int MAX_GAP = 13;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 310;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		vfoc_mode_t mode;
		logic [STEPS_IN_W-1:0] fade_steps;
		logic start_ok;
		logic player_playing;
	} fade_cmd_t;

	typedef struct packed {
		logic [VOL_W-1:0] volume;
		logic volume_valid;
		logic halt_player;
		logic active;
		logic fading;
	} fade_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [VOL_W-1:0] master_volume;
	logic in_valid;
	logic in_ready;
	logic [1:0] mode;
	logic [STEPS_IN_W-1:0] fade_steps;
	logic start_ok;
	logic player_playing;
	logic out_valid;
	logic out_ready;
	logic [VOL_W-1:0] volume;
	logic volume_valid;
	logic halt_player;
	logic active;
	logic fading;

	fade_cmd_t cur_cmd;
	fade_cmd_t pending_cmds[$];
	fade_result_t gain_updates_due[$];

	// Shadow of the block's register and ramp state.
	logic [VOL_W-1:0] gain_master;
	logic playing_flag;
	logic [STEPS_IN_W-1:0] ramp_left;
	logic [LEVEL_W-1:0] ramp_lvl;
	logic [LEVEL_W-1:0] ramp_stp;
	logic [LEVEL_W-1:0] ramp_tgt;

	logic in_fire;
	logic out_fire;
	int in_gap;
	int out_hold;
	bit in_calm;
	bit out_calm;
	int err_count;
	int idle_cycles;
	int queued;

	assign mode = cur_cmd.mode;
	assign fade_steps = cur_cmd.fade_steps;
	assign start_ok = cur_cmd.start_ok;
	assign player_playing = cur_cmd.player_playing;

	volume_fade_out_controller u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.master_volume(master_volume),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.fade_steps(fade_steps),
		.start_ok(start_ok),
		.player_playing(player_playing),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.volume(volume),
		.volume_valid(volume_valid),
		.halt_player(halt_player),
		.active(active),
		.fading(fading)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report(string msg);
		if (err_count < MAX_PRINTED) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
		err_count++;
	endtask

	function automatic fade_result_t ramp_predict(fade_cmd_t c);
		fade_result_t r;
		logic [LEVEL_W+VOL_W-1:0] prod;
		r = '0;
		case (c.mode)
			MODE_START: begin
				r.halt_player = playing_flag;
				ramp_left = '0;
				ramp_lvl = LEVEL_ONE;
				ramp_stp = LEVEL_ONE;
				ramp_tgt = LEVEL_ONE;
				r.volume_valid = 1'b1;
				playing_flag = c.start_ok;
			end
			MODE_STOP: begin
				if (playing_flag) begin
					if (c.fade_steps == '0) begin
						r.halt_player = 1'b1;
						playing_flag = 1'b0;
					end else begin
						ramp_tgt = '0;
						ramp_left = c.fade_steps;
						ramp_stp = ramp_lvl / LEVEL_W'(c.fade_steps);
					end
				end
			end
			MODE_TICK: begin
				if (ramp_left != '0) begin
					ramp_left = ramp_left - 1'b1;
					if (ramp_left != '0) begin
						ramp_lvl = (ramp_lvl > ramp_stp) ? ramp_lvl - ramp_stp : '0;
						r.volume_valid = 1'b1;
					end else begin
						ramp_lvl = ramp_tgt;
						if (playing_flag) begin
							r.halt_player = 1'b1;
							playing_flag = 1'b0;
						end
					end
				end
				if (playing_flag) begin
					playing_flag = c.player_playing;
				end
			end
			default: begin
			end
		endcase
		prod = ramp_lvl * gain_master;
		prod = prod >> LEVEL_FRAC;
		r.volume = (prod > 'hFFFF) ? VOL_W'('hFFFF) : prod[VOL_W-1:0];
		r.active = playing_flag;
		r.fading = (ramp_left != '0);
		return r;
	endfunction

	// Input side: one transaction per pending command, with random gaps.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cur_cmd <= pending_cmds.pop_front();
					in_valid <= 1'b1;
					if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
					in_gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output side: random stall after each accepted result.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire) begin
				if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
				out_hold = out_calm ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (out_hold > 0) begin
				out_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		fade_result_t want;
		if (arst_n) begin
			in_fire <= in_valid && in_ready;
			out_fire <= out_valid && out_ready;
			if (out_valid && out_ready) begin
				if (gain_updates_due.size() == 0) begin
					report("result transaction with nothing expected");
				end else begin
					want = gain_updates_due.pop_front();
					if (volume !== want.volume)
						report($sformatf("volume got %0d expected %0d", volume, want.volume));
					if (volume_valid !== want.volume_valid)
						report($sformatf("volume_valid got %b expected %b", volume_valid,
							want.volume_valid));
					if (halt_player !== want.halt_player)
						report($sformatf("halt_player got %b expected %b", halt_player,
							want.halt_player));
					if (active !== want.active)
						report($sformatf("active got %b expected %b", active, want.active));
					if (fading !== want.fading)
						report($sformatf("fading got %b expected %b", fading, want.fading));
				end
			end
			if (in_valid && in_ready) begin
				gain_updates_due.push_back(ramp_predict(cur_cmd));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic queue_cmd(vfoc_mode_t m, logic [STEPS_IN_W-1:0] n, logic ok, logic play);
		fade_cmd_t c;
		c.mode = m;
		c.fade_steps = n;
		c.start_ok = ok;
		c.player_playing = play;
		pending_cmds.push_back(c);
		queued++;
	endtask

	task automatic queue_tick(logic play);
		queue_cmd(MODE_TICK, STEPS_IN_W'($urandom), 1'($urandom), play);
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || in_valid || gain_updates_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_master(logic [VOL_W-1:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		master_volume <= v;
		gain_master = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly complete start, stop and fade sequences; the rest is random noise.
	task automatic queue_random(int count);
		int target;
		int pick;
		int ticks;
		logic [STEPS_IN_W-1:0] n;
		target = queued + count;
		while (queued < target) begin
			if ($urandom_range(0, 9) < 8) begin
				queue_cmd(MODE_START, STEPS_IN_W'($urandom), $urandom_range(0, 7) != 0,
					1'($urandom));
				repeat ($urandom_range(0, 3)) queue_tick($urandom_range(0, 15) != 0);
				pick = $urandom_range(0, 19);
				if (pick == 0) n = '0;
				else if (pick < 13) n = STEPS_IN_W'($urandom_range(1, 8));
				else if (pick < 18) n = STEPS_IN_W'($urandom_range(9, 64));
				else n = STEPS_IN_W'($urandom);
				queue_cmd(MODE_STOP, n, 1'($urandom), 1'($urandom));
				ticks = (n <= 64) ? int'(n) + $urandom_range(0, 2) : $urandom_range(0, 20);
				repeat (ticks) queue_tick($urandom_range(0, 15) != 0);
			end else begin
				repeat ($urandom_range(1, 4)) begin
					queue_cmd(vfoc_mode_t'($urandom_range(0, 3)), STEPS_IN_W'($urandom),
						1'($urandom), 1'($urandom));
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		master_volume = MASTER_RESET;
		in_valid = 1'b0;
		out_ready = 1'b0;
		cur_cmd = '0;
		in_fire = 1'b0;
		out_fire = 1'b0;
		in_gap = 0;
		out_hold = 0;
		in_calm = 1'b0;
		out_calm = 1'b0;
		err_count = 0;
		idle_cycles = 0;
		queued = 0;
		gain_master = MASTER_RESET;
		playing_flag = 1'b0;
		ramp_left = '0;
		ramp_lvl = LEVEL_ONE;
		ramp_stp = LEVEL_ONE;
		ramp_tgt = LEVEL_ONE;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		set_master(MASTER_RESET);
		queue_cmd(MODE_TICK, '0, 1'b0, 1'b1);
		queue_cmd(MODE_STOP, 16'd5, 1'b1, 1'b1);
		queue_cmd(MODE_START, '0, 1'b0, 1'b0);
		queue_cmd(MODE_START, '0, 1'b1, 1'b0);
		queue_cmd(MODE_START, 16'hFFFF, 1'b1, 1'b1);
		queue_cmd(MODE_STOP, '0, 1'b0, 1'b0);
		queue_cmd(MODE_START, '0, 1'b1, 1'b0);
		queue_cmd(MODE_STOP, 16'd1, 1'b0, 1'b0);
		queue_cmd(MODE_TICK, 16'hFFFF, 1'b1, 1'b1);
		queue_cmd(MODE_START, '0, 1'b1, 1'b0);
		queue_cmd(MODE_STOP, 16'hFFFF, 1'b1, 1'b1);
		queue_cmd(MODE_TICK, '0, 1'b0, 1'b1);
		queue_cmd(MODE_TICK, '0, 1'b0, 1'b1);
		queue_cmd(MODE_NOP, 16'hFFFF, 1'b1, 1'b1);
		queue_cmd(MODE_START, '0, 1'b1, 1'b0);
		queue_cmd(MODE_STOP, 16'd3, 1'b0, 1'b0);
		queue_cmd(MODE_TICK, '0, 1'b0, 1'b0);
		queue_cmd(MODE_TICK, '0, 1'b0, 1'b1);
		queue_cmd(MODE_TICK, '0, 1'b0, 1'b1);
		queue_cmd(MODE_TICK, '0, 1'b0, 1'b1);
		queue_cmd(MODE_START, '0, 1'b1, 1'b0);
		queue_cmd(MODE_STOP, 16'h5555, 1'b0, 1'b0);
		queue_cmd(MODE_TICK, 16'hAAAA, 1'b1, 1'b1);
		queue_cmd(MODE_STOP, 16'hAAAA, 1'b1, 1'b1);
		queue_cmd(MODE_TICK, 16'h5555, 1'b0, 1'b1);

		set_master(16'd0);
		queue_random(PHASE_ITEMS);
		set_master(16'hFFFF);
		queue_random(PHASE_ITEMS);
		set_master(VOL_W'($urandom_range(0, 65535)));
		queue_random(PHASE_ITEMS);
		set_master(16'd1);
		queue_random(PHASE_ITEMS);
		set_master(VOL_W'($urandom_range(0, 65535)));
		queue_random(PHASE_ITEMS);
		set_master(MASTER_RESET);
		queue_random(PHASE_ITEMS);

		wait_drained();
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
